// ===== hw/rtl/pfp_pkg.sv =====
package pfp_pkg;

  // Number of pipeline stages in the square root and reciprocal units.
  localparam int unsigned SQRT_STAGES  = 31;
  localparam int unsigned RECIP_STAGES = 32;

  // Fraction bits of the unit normal.
  localparam int unsigned NORMAL_FRAC = 30;

  // Side information that travels with a request through the long units.
  typedef struct packed {
    logic [2:0][29:0] m;      // block-normalised cross product magnitudes
    logic [2:0]       neg;    // cross product signs
    logic [2:0][31:0] p1;     // first point, needed for the offset
    logic             degen;  // cross product was exactly zero
  } carry_t;

endpackage

// ===== hw/rtl/pfp_isqrt.sv =====
module pfp_isqrt
  import pfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [61:0] in_sum,
  input  carry_t      in_carry,
  output logic        out_valid,
  output logic [30:0] out_root,
  output carry_t      out_carry
);

  typedef struct packed {
    logic [62:0] s;
    logic [62:0] r;
  } sq_t;

  function automatic sq_t sqrt_step(sq_t a, logic [62:0] bw);
    sq_t o;
    logic [62:0] t;
    t = a.r + bw;
    if (a.s >= t) begin
      o.s = a.s - t;
      o.r = (a.r >> 1) + bw;
    end else begin
      o.s = a.s;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  sq_t    st    [SQRT_STAGES];
  logic   vld   [SQRT_STAGES];
  carry_t cry   [SQRT_STAGES];

  for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_stage
    localparam logic [62:0] BW = 63'd1 << (2 * (SQRT_STAGES - 1 - j));
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (en) begin
          vld[j] <= in_valid;
        end
        if (en) begin
          st[j]  <= sqrt_step('{s: {1'b0, in_sum}, r: 63'd0}, BW);
          cry[j] <= in_carry;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (en) begin
          vld[j] <= vld[j-1];
        end
        if (en) begin
          st[j]  <= sqrt_step(st[j-1], BW);
          cry[j] <= cry[j-1];
        end
      end
    end
  end

  assign out_valid = vld[SQRT_STAGES-1];
  assign out_root  = st[SQRT_STAGES-1].r[30:0];
  assign out_carry = cry[SQRT_STAGES-1];

endmodule

// ===== hw/rtl/pfp_recip.sv =====
module pfp_recip
  import pfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [30:0] in_root,
  input  carry_t      in_carry,
  output logic        out_valid,
  output logic [31:0] out_inv,
  output carry_t      out_carry
);

  // Restoring division of 2^60 by the root, one quotient bit per stage.
  typedef struct packed {
    logic [31:0] rem;
    logic [31:0] q;
    logic [30:0] d;
  } dv_t;

  function automatic dv_t div_step(dv_t a);
    dv_t o;
    logic [32:0] t;
    t = {a.rem, 1'b0};
    o.d = a.d;
    if (t >= {2'b00, a.d}) begin
      o.rem = 32'(t - {2'b00, a.d});
      o.q   = {a.q[30:0], 1'b1};
    end else begin
      o.rem = t[31:0];
      o.q   = {a.q[30:0], 1'b0};
    end
    return o;
  endfunction

  dv_t    st  [RECIP_STAGES];
  logic   vld [RECIP_STAGES];
  carry_t cry [RECIP_STAGES];

  for (genvar j = 0; j < RECIP_STAGES; j++) begin : g_stage
    if (j == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (en) begin
          vld[j] <= in_valid;
        end
        if (en) begin
          st[j]  <= div_step('{rem: 32'd1 << 28, q: 32'd0, d: in_root});
          cry[j] <= in_carry;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[j] <= 1'b0;
        end else if (en) begin
          vld[j] <= vld[j-1];
        end
        if (en) begin
          st[j]  <= div_step(st[j-1]);
          cry[j] <= cry[j-1];
        end
      end
    end
  end

  assign out_valid = vld[RECIP_STAGES-1];
  assign out_inv   = st[RECIP_STAGES-1].q;
  assign out_carry = cry[RECIP_STAGES-1];

endmodule

// ===== hw/rtl/plane_from_three_points.sv =====
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  three points, 288 bits of tdata
// m_*      out        m_tvalid / m_tready  unit normal and offset in tdata, degenerate in tuser
//
// One request is accepted every cycle while the output side does not stall; the pipeline is made of the
// 31 stages of the square root unit, the 32 stages of the reciprocal unit and ten others.
// Reset clears every valid bit of the pipeline and the output register.
// The whole pipeline advances together whenever the output register is empty or being
// taken, so a stall on the output side holds every stage and the input ready falls.
module plane_from_three_points
  import pfp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, 32 bits each
  input  logic [287:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // normal_x, normal_y, normal_z (32 bits each), plane_offset (40 bits)
  output logic [135:0] m_tdata,
  // degenerate
  output logic         m_tuser
);

  // Global advance: every stage moves when the output register can take a result.
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // Stage 1: edge vectors e1 = p2 - p1 and e2 = p2 - p3, exact in 33 bits.
  logic                v1;
  logic signed [32:0]  e1 [3];
  logic signed [32:0]  e2 [3];
  logic [2:0][31:0]    p1_1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e1[i]   <= $signed({s_tdata[32*(3+i)+31], s_tdata[32*(3+i) +: 32]})
                 - $signed({s_tdata[32*i+31], s_tdata[32*i +: 32]});
        e2[i]   <= $signed({s_tdata[32*(3+i)+31], s_tdata[32*(3+i) +: 32]})
                 - $signed({s_tdata[32*(6+i)+31], s_tdata[32*(6+i) +: 32]});
        p1_1[i] <= s_tdata[32*i +: 32];
      end
    end
  end

  // Stage 2: the six partial products of the cross product.
  logic                v2;
  logic signed [65:0]  pa [3];
  logic signed [65:0]  pb [3];
  logic [2:0][31:0]    p1_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
    if (adv) begin
      pa[0] <= e1[1] * e2[2];
      pb[0] <= e1[2] * e2[1];
      pa[1] <= e1[2] * e2[0];
      pb[1] <= e1[0] * e2[2];
      pa[2] <= e1[0] * e2[1];
      pb[2] <= e1[1] * e2[0];
      p1_2  <= p1_1;
    end
  end

  // Stage 3: cross product components as sign and magnitude.
  logic                v3;
  logic [65:0]         mag3 [3];
  logic [2:0]          neg3;
  logic [2:0][31:0]    p1_3;
  logic signed [66:0]  diff [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff[i] = 67'(pa[i]) - 67'(pb[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= diff[i][66];
        mag3[i] <= diff[i][66] ? 66'(-diff[i]) : 66'(diff[i]);
      end
      p1_3 <= p1_2;
    end
  end

  // Stage 4: bit length of the largest magnitude, taken from the OR of all three.
  logic                v4;
  logic [6:0]          blen;
  logic [6:0]          blen_next;
  logic [65:0]         mag4 [3];
  logic [2:0]          neg4;
  logic [2:0][31:0]    p1_4;
  logic [65:0]         orv;

  always_comb begin
    orv       = mag3[0] | mag3[1] | mag3[2];
    blen_next = 7'd0;
    for (int i = 0; i < 66; i++) begin
      if (orv[i]) begin
        blen_next = 7'(i + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (adv) begin
      v4 <= v3;
    end
    if (adv) begin
      blen <= blen_next;
      mag4 <= mag3;
      neg4 <= neg3;
      p1_4 <= p1_3;
    end
  end

  // Stage 5: block normalisation so that the largest component tops out at bit 29.
  logic    v5;
  carry_t  c5;
  carry_t  c5_next;

  always_comb begin
    c5_next.neg   = neg4;
    c5_next.p1    = p1_4;
    c5_next.degen = (blen == 7'd0);
    for (int i = 0; i < 3; i++) begin
      if (blen > 7'd30) begin
        c5_next.m[i] = 30'(mag4[i] >> (blen - 7'd30));
      end else begin
        c5_next.m[i] = 30'(mag4[i] << (7'd30 - blen));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (adv) begin
      v5 <= v4;
    end
    if (adv) begin
      c5 <= c5_next;
    end
  end

  // Stage 6: squares of the normalised components.
  logic        v6;
  logic [59:0] sq [3];
  carry_t      c6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (adv) begin
      v6 <= v5;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq[i] <= c5.m[i] * c5.m[i];
      end
      c6 <= c5;
    end
  end

  // Stage 7: sum of squares, below 3 * 2^60.
  logic        v7;
  logic [61:0] ssum;
  carry_t      c7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (adv) begin
      v7 <= v6;
    end
    if (adv) begin
      ssum <= 62'(sq[0]) + 62'(sq[1]) + 62'(sq[2]);
      c7   <= c6;
    end
  end

  // Integer square root, then the reciprocal 2^60 / root.
  logic        sq_valid;
  logic [30:0] sq_root;
  carry_t      sq_carry;
  logic        rc_valid;
  logic [31:0] rc_inv;
  carry_t      rc_carry;

  pfp_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v7),
    .in_sum    (ssum),
    .in_carry  (c7),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_carry (sq_carry)
  );

  pfp_recip u_recip (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (sq_valid),
    .in_root   (sq_root),
    .in_carry  (sq_carry),
    .out_valid (rc_valid),
    .out_inv   (rc_inv),
    .out_carry (rc_carry)
  );

  // Stage 8: normal components, scaled magnitude with the sign put back.
  logic               v8;
  logic signed [31:0] nrm8 [3];
  logic [2:0][31:0]   p1_8;
  logic               dg8;
  logic [61:0]        scl [3];
  logic [31:0]        vmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      scl[i]  = rc_carry.m[i] * rc_inv;
      vmag[i] = scl[i][61:NORMAL_FRAC];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (adv) begin
      v8 <= rc_valid;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        nrm8[i] <= rc_carry.neg[i] ? $signed(-vmag[i]) : $signed(vmag[i]);
      end
      p1_8 <= rc_carry.p1;
      dg8  <= rc_carry.degen;
    end
  end

  // Stage 9: products of the first point with the normal.
  logic               v9;
  logic signed [63:0] dp [3];
  logic signed [31:0] nrm9 [3];
  logic               dg9;

  always_ff @(posedge clk) begin
    if (rst) begin
      v9 <= 1'b0;
    end else if (adv) begin
      v9 <= v8;
    end
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        dp[i] <= $signed(p1_8[i]) * nrm8[i];
      end
      nrm9 <= nrm8;
      dg9  <= dg8;
    end
  end

  // Output register: offset = -(p1 . n) rounded to nearest, halves upward.
  logic signed [65:0] dsum;
  logic signed [65:0] rnd;

  always_comb begin
    dsum = 66'(dp[0]) + 66'(dp[1]) + 66'(dp[2]);
    rnd  = (66'sd0 - dsum) + (66'sd1 <<< (NORMAL_FRAC - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= v9;
    end
    if (adv) begin
      m_tuser <= dg9;
      if (dg9) begin
        m_tdata <= '0;
      end else begin
        m_tdata[31:0]   <= nrm9[0];
        m_tdata[63:32]  <= nrm9[1];
        m_tdata[95:64]  <= nrm9[2];
        m_tdata[135:96] <= 40'(rnd >>> NORMAL_FRAC);
      end
    end
  end

`ifndef SYNTHESIS
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata == '0))
    else $error("degenerate result carries non-zero fields");

  a_root_low: assert property (@(posedge clk) disable iff (rst)
    (sq_valid && !sq_carry.degen) |-> (sq_root >= 31'h2000_0000))
    else $error("square root below 2^29 after normalisation");

  a_inv_range: assert property (@(posedge clk) disable iff (rst)
    (rc_valid && !rc_carry.degen) |->
      (rc_inv >= 32'h2000_0000 && rc_inv <= 32'h8000_0000))
    else $error("reciprocal out of range");

  a_nrm_range: assert property (@(posedge clk) disable iff (rst)
    (v9 && !dg9) |->
      (nrm9[0] <= 32'sd1073741824 && nrm9[0] >= -32'sd1073741824 &&
       nrm9[1] <= 32'sd1073741824 && nrm9[1] >= -32'sd1073741824 &&
       nrm9[2] <= 32'sd1073741824 && nrm9[2] >= -32'sd1073741824))
    else $error("normal component exceeds unit magnitude");
`endif

endmodule

// ===== test/plane_checker.sv =====
`timescale 1ns / 100ps

module plane_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [287:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  input  logic         m_tuser,
  output int           fail_count,
  output int           pending_planes,
  output int           planes_seen,
  output int           degen_seen
);

  typedef struct packed {
    logic [31:0] nx;
    logic [31:0] ny;
    logic [31:0] nz;
    logic [39:0] offset;
    logic        degen;
  } plane_t;

  plane_t plane_queue[$];

  function automatic longint unsigned isqrt(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic plane_t plane_of(logic [287:0] d);
    logic signed [33:0] p[9];
    logic signed [33:0] e1[3];
    logic signed [33:0] e2[3];
    logic signed [69:0] c[3];
    logic [69:0] mag[3];
    longint unsigned m[3];
    longint unsigned s, r, inv;
    logic signed [63:0] n[3];
    logic signed [63:0] dot;
    logic signed [63:0] off;
    int blen;
    plane_t res;
    for (int i = 0; i < 9; i++) p[i] = {{2{d[32*i+31]}}, d[32*i +: 32]};
    for (int i = 0; i < 3; i++) begin
      e1[i] = p[3+i] - p[i];
      e2[i] = p[3+i] - p[6+i];
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    blen = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = c[i] < 0 ? -c[i] : c[i];
      for (int b = 0; b < 70; b++) if (mag[i][b] && b + 1 > blen) blen = b + 1;
    end
    res = '0;
    if (blen == 0) begin
      res.degen = 1'b1;
      return res;
    end
    // All three magnitudes share one shift so the top bit of the largest lands at bit 29.
    for (int i = 0; i < 3; i++)
      m[i] = blen > 30 ? 64'(mag[i] >> (blen - 30)) : 64'(mag[i] << (30 - blen));
    s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    r = isqrt(s);
    inv = (64'd1 << 60) / r;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      n[i] = (m[i] * inv) >> 30;
      if (c[i] < 0) n[i] = -n[i];
      dot += p[i] * n[i];
    end
    off = (-dot + (64'sd1 << 29)) >>> 30;
    res.nx = n[0][31:0];
    res.ny = n[1][31:0];
    res.nz = n[2][31:0];
    res.offset = off[39:0];
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [39:0] got, logic [39:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_planes = 0;
    planes_seen = 0;
    degen_seen = 0;
  end

  always @(posedge clk) begin
    plane_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) plane_queue.push_back(plane_of(s_tdata));
      if (m_tvalid && m_tready) begin
        planes_seen++;
        if (m_tuser) degen_seen++;
        if (plane_queue.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[39:0], '0);
        end else begin
          want = plane_queue.pop_front();
          if (m_tdata[31:0] !== want.nx) report_mismatch("normal_x", m_tdata[31:0], want.nx);
          if (m_tdata[63:32] !== want.ny) report_mismatch("normal_y", m_tdata[63:32], want.ny);
          if (m_tdata[95:64] !== want.nz) report_mismatch("normal_z", m_tdata[95:64], want.nz);
          if (m_tdata[135:96] !== want.offset)
            report_mismatch("plane_offset", m_tdata[135:96], want.offset);
          if (m_tuser !== want.degen) report_mismatch("degenerate", m_tuser, want.degen);
        end
      end
      pending_planes = plane_queue.size();
    end
  end

endmodule

// ===== test/tb_plane_from_three_points.sv =====
`timescale 1ns / 100ps

module tb_plane_from_three_points;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // p1_x, p1_y, p1_z, p2_x, p2_y, p2_z, p3_x, p3_y, p3_z, 32 bits each
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  // normal_x, normal_y, normal_z, plane_offset
  logic [135:0] m_tdata;
  // degenerate
  logic         m_tuser;

  int fail_count, pending_planes, planes_seen, degen_seen;
  int triangles_sent;
  bit stimulus_done;
  bit long_hold;

  localparam int PIPE_LATENCY = 73;
  localparam int RANDOM_TRIANGLES = 650;

  plane_from_three_points u_dut (.*);

  plane_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Ends a hung run well beyond the slowest legitimate schedule.
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Builds a triangle of random kind. Some are general triangles with points
  // of moderate size, some are full range, some are degenerate by repetition
  // or collinearity, and some sit on or near the coordinate extremes.
  function automatic logic [287:0] random_triangle();
    logic [31:0] c[9];
    int kind;
    int shift;
    kind = $urandom_range(0, 9);
    shift = $urandom_range(0, 31);
    for (int i = 0; i < 9; i++) c[i] = $urandom;
    case (kind)
      0, 1, 2: begin
        for (int i = 0; i < 9; i++) c[i] = $signed(c[i]) >>> shift;
      end
      3: begin
        c[6] = c[0]; c[7] = c[1]; c[8] = c[2];
      end
      4: begin
        // p3 mirrors p1 about p2, so the three points lie on one line.
        for (int i = 0; i < 3; i++) begin
          c[i] = $signed(c[i]) >>> 2;
          c[3+i] = $signed(c[3+i]) >>> 2;
          c[6+i] = 2 * c[3+i] - c[i];
        end
      end
      5: begin
        for (int i = 0; i < 9; i++)
          c[i] = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                      : 32'h7fff_ffff - $urandom_range(0, 3);
      end
      6: begin
        // Small integer lattice: exact cases and tiny cross products.
        for (int i = 0; i < 9; i++) c[i] = $signed($urandom_range(0, 8)) - 4;
      end
      default: ;
    endcase
    return {c[8], c[7], c[6], c[5], c[4], c[3], c[2], c[1], c[0]};
  endfunction

  task automatic send_triangle(logic [287:0] tri_data);
    s_tvalid <= 1'b1;
    s_tdata  <= tri_data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    triangles_sent++;
  endtask

  task automatic idle_gap();
    if ($urandom_range(0, 3) != 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Receiver stalls on a pattern of its own; once, it holds off long enough
  // for the whole pipeline to fill and the input side to stall.
  initial begin
    int phase;
    m_tready = 1'b0;
    phase = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      phase++;
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end else if (phase % 300 < 60) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    logic [31:0] extremes[6];
    int wait_cycles;
    extremes = '{32'h0000_0000, 32'h0000_0001, 32'hffff_ffff,
                 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000};
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    triangles_sent = 0;
    stimulus_done = 1'b0;
    long_hold = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: unit axes, all points equal, collinear, full-range corners,
    // and several coordinates pinned to each extreme in turn.
    send_triangle({32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0,
                   32'h0, 32'h0, 32'h0});
    send_triangle('0);
    send_triangle({9{32'h1234_5678}});
    send_triangle({32'h0003_0000, 32'h0003_0000, 32'h0003_0000,
                   32'h0002_0000, 32'h0002_0000, 32'h0002_0000,
                   32'h0001_0000, 32'h0001_0000, 32'h0001_0000});
    send_triangle({32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                   32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000});
    send_triangle({32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                   32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000});
    send_triangle({32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001,
                   32'h7fff_ffff, 32'h0, 32'h8000_0000,
                   32'h0, 32'h8000_0000, 32'h7fff_ffff});
    for (int i = 0; i < 6; i++) begin
      send_triangle({{3{extremes[i]}}, 32'h0, 32'h0, 32'h0,
                     extremes[5 - i], extremes[i], 32'h0});
      send_triangle({extremes[i], 32'h0, extremes[5 - i], 32'h0, extremes[i],
                     extremes[5 - i], 32'hffff_ffff, extremes[i], 32'h8000_0000});
    end

    // Random traffic in bursts, with the long receiver hold part way through.
    for (int n = 0; n < RANDOM_TRIANGLES; n++) begin
      if (n == 200) long_hold = 1'b1;
      send_triangle(random_triangle());
      if ($urandom_range(0, 7) == 0) idle_gap();
    end
    s_tvalid <= 1'b0;
    stimulus_done = 1'b1;

    wait_cycles = 0;
    while (pending_planes != 0 && wait_cycles < 100000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * PIPE_LATENCY) @(posedge clk);

    $display("%0d triangles sent, %0d planes checked, %0d degenerate.",
             triangles_sent, planes_seen, degen_seen);
    if (fail_count == 0 && pending_planes == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/pfp_pkg.sv
hw/rtl/pfp_isqrt.sv
hw/rtl/pfp_recip.sv
hw/rtl/plane_from_three_points.sv
test/plane_checker.sv
test/tb_plane_from_three_points.sv
